[rtl/core/whitney_one_form_to_face_vector_top_defines.svh]
// assertion macros for the whitney face vector block
`ifndef WHITNEY_ONE_FORM_TO_FACE_VECTOR_TOP_DEFINES_SVH
`define WHITNEY_ONE_FORM_TO_FACE_VECTOR_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define WOF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define WOF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/wof_pkg.sv]
// shared types, constants and rounding helper for the whitney face vector block
package wof_pkg;

  localparam int DEF_COORD_BITS = 20;
  localparam int DEF_FORM_BITS  = 24;
  localparam int FRAC           = 12;
  localparam int AREA_BITS      = 32;
  localparam int DIV_SCALE      = 20;
  localparam int DIV_STEPS      = 40;
  localparam int RND_W          = 80;

  localparam logic [DIV_STEPS-1:0] R_MAX = '1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef struct packed {
    logic [59:0]        corner_a;
    logic [59:0]        corner_b;
    logic [59:0]        corner_c;
    logic [59:0]        face_normal;
    logic [59:0]        tangent_x;
    logic [59:0]        tangent_y;
    logic [31:0]        face_area;
    logic signed [23:0] form_edge0;
    logic signed [23:0] form_edge1;
    logic signed [23:0] form_edge2;
    logic [5:0]         edge_flags;
  } in_t;

  typedef struct packed {
    logic signed [31:0] vec_u;
    logic signed [31:0] vec_v;
    logic [1:0]         status;
  } out_t;

  // drop FRAC fraction bits, nearest with ties away from zero
  function automatic logic signed [RND_W-1:0] rnd_frac(input logic signed [RND_W-1:0] x);
    logic signed [RND_W-1:0] bias;
    bias = $signed({{(RND_W-1){1'b0}}, ~x[RND_W-1]});
    return (x + RND_W'(2047) + bias) >>> FRAC;
  endfunction

endpackage

[rtl/core/wof_div.sv]
// pipelined restoring divider, one quotient bit per stage
module wof_div import wof_pkg::*; #(
  parameter int DB    = AREA_BITS + 3,
  parameter int LOB   = DIV_SCALE,
  parameter int STEPS = DIV_STEPS
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DB:0]      rem_in,
  input  logic [LOB-1:0]   lo_in,
  input  logic [DB-1:0]    d_in,
  output logic [STEPS-1:0] q_out
);

  logic [DB:0]      rem_r [STEPS];
  logic [LOB-1:0]   lo_r  [STEPS];
  logic [DB-1:0]    d_r   [STEPS];
  logic [STEPS-1:0] q_r   [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    logic [DB:0]      rem_p;
    logic [LOB-1:0]   lo_p;
    logic [DB-1:0]    d_p;
    logic [STEPS-1:0] q_p;
    logic [DB+1:0]    t;
    logic [DB+1:0]    diff;
    logic             ge;
    if (i == 0) begin : g_first
      assign rem_p = rem_in;
      assign lo_p  = lo_in;
      assign d_p   = d_in;
      assign q_p   = '0;
    end else begin : g_next
      assign rem_p = rem_r[i-1];
      assign lo_p  = lo_r[i-1];
      assign d_p   = d_r[i-1];
      assign q_p   = q_r[i-1];
    end
    // partial remainder stays below the divisor, so t is below twice it
    assign t    = {rem_p, lo_p[LOB-1]};
    assign diff = t - {2'b00, d_p};
    assign ge   = (t >= {2'b00, d_p});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? diff[DB:0] : t[DB:0];
        lo_r[i]  <= {lo_p[LOB-2:0], 1'b0};
        d_r[i]   <= d_p;
        q_r[i]   <= {q_p[STEPS-2:0], ge};
      end
    end
  end

  assign q_out = q_r[STEPS-1];

endmodule

[rtl/core/whitney_one_form_to_face_vector_top.sv]
// top level of the whitney one-form to face tangent vector pipeline
//
// One triangle enters per clock; the sustained rate is one item per cycle
// while no result waits at the output. The depth is set by the 40-stage
// restoring divider (one quotient bit per stage, three lanes side by side)
// that scales the summed field by 1 / (6 * area), plus six stages before it
// for edge, cross-product and weight arithmetic and four after it for
// projection, rounding and clamping. The whole pipeline holds while a result
// waits at the output; in_ready follows that hold in the same cycle.
module whitney_one_form_to_face_vector_top import wof_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int FORM_BITS  = DEF_FORM_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

`include "whitney_one_form_to_face_vector_top_defines.svh"

  localparam int CB  = COORD_BITS;
  localparam int FB  = FORM_BITS;
  localparam int EB  = CB + 1;
  localparam int XB  = 2 * CB + 2;
  localparam int CRB = 2 * CB - 9;
  localparam int FWB = FB + 1;
  localparam int WB  = FB + 2;
  localparam int PB  = WB + CRB;
  localparam int TB  = PB - 11;
  localparam int NB  = TB + 2;
  localparam int DB  = AREA_BITS + 3;
  localparam int CW  = NB + DB + DIV_SCALE;
  localparam int RB  = DIV_STEPS + 2;
  localparam int PJ  = RB + CB;
  localparam int SB  = PJ + 2;
  localparam int NST = 10 + DIV_STEPS;

  typedef struct packed {
    logic                zero;
    logic [3*CB-1:0]     tx;
    logic [3*CB-1:0]     ty;
  } side_t;

  typedef struct packed {
    side_t      s;
    logic [2:0] neg;
    logic [2:0] sat;
  } dside_t;

  function automatic logic signed [CB-1:0] comp(input logic [59:0] w, input int k);
    logic [3*CB-1:0] x;
    x = (3*CB)'(w);
    return $signed(x[k*CB +: CB]);
  endfunction

  logic en;
  logic [NST-1:0] vld_r;

  assign en       = !vld_r[NST-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // stage 1: edge vectors and signed form values
  logic signed [EB-1:0]  e1_r [3][3];
  logic signed [CB-1:0]  n1_r [3];
  logic signed [FWB-1:0] f1_r [3];
  logic [AREA_BITS-1:0]  area1_r;
  side_t                 side1_r;

  logic [59:0]        corner [3];
  logic signed [23:0] form   [3];
  assign corner[0] = in_data.corner_a;
  assign corner[1] = in_data.corner_b;
  assign corner[2] = in_data.corner_c;
  assign form[0]   = in_data.form_edge0;
  assign form[1]   = in_data.form_edge1;
  assign form[2]   = in_data.form_edge2;

  for (genvar j = 0; j < 3; j++) begin : g_s1
    logic [31:0]          fz;
    logic signed [FWB-1:0] fv;
    assign fz = {8'd0, form[j]};
    assign fv = FWB'($signed(fz[FB-1:0]));
    for (genvar k = 0; k < 3; k++) begin : g_k
      always_ff @(posedge clk) begin
        if (en) begin
          e1_r[j][k] <= EB'(comp(corner[(j+1)%3], k)) - EB'(comp(corner[j], k));
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n1_r[j] <= comp(in_data.face_normal, j);
        f1_r[j] <= (in_data.edge_flags[j] != in_data.edge_flags[3+j]) ? fv : -fv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      area1_r       <= in_data.face_area;
      side1_r.zero  <= (in_data.face_area == '0);
      side1_r.tx    <= (3*CB)'(in_data.tangent_x);
      side1_r.ty    <= (3*CB)'(in_data.tangent_y);
    end
  end

  // stage 2: cross-product partial products and whitney weights
  logic signed [XB-2:0] pa2_r [3][3];
  logic signed [XB-2:0] pb2_r [3][3];
  logic signed [WB-1:0] w2_r  [3];
  logic [AREA_BITS-1:0] area2_r;
  side_t                side2_r;

  for (genvar j = 0; j < 3; j++) begin : g_s2
    for (genvar k = 0; k < 3; k++) begin : g_k
      always_ff @(posedge clk) begin
        if (en) begin
          pa2_r[j][k] <= (XB-1)'(e1_r[j][(k+1)%3] * n1_r[(k+2)%3]);
          pb2_r[j][k] <= (XB-1)'(e1_r[j][(k+2)%3] * n1_r[(k+1)%3]);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        w2_r[j] <= WB'(f1_r[(j+1)%3]) - WB'(f1_r[(j+2)%3]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      area2_r <= area1_r;
      side2_r <= side1_r;
    end
  end

  // stage 3: cross vectors rounded to 12 fraction bits
  logic signed [CRB-1:0] cr3_r [3][3];
  logic signed [WB-1:0]  w3_r  [3];
  logic [AREA_BITS-1:0]  area3_r;
  side_t                 side3_r;

  for (genvar j = 0; j < 3; j++) begin : g_s3
    for (genvar k = 0; k < 3; k++) begin : g_k
      logic signed [XB-1:0]    xd;
      logic signed [RND_W-1:0] xr;
      assign xd = XB'(pa2_r[j][k]) - XB'(pb2_r[j][k]);
      assign xr = rnd_frac(RND_W'(xd));
      always_ff @(posedge clk) begin
        if (en) begin
          cr3_r[j][k] <= xr[CRB-1:0];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        w3_r[j] <= w2_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      area3_r <= area2_r;
      side3_r <= side2_r;
    end
  end

  // stage 4: weight times cross vector
  logic signed [PB-1:0] wp4_r [3][3];
  logic [AREA_BITS-1:0] area4_r;
  side_t                side4_r;

  for (genvar j = 0; j < 3; j++) begin : g_s4
    for (genvar k = 0; k < 3; k++) begin : g_k
      always_ff @(posedge clk) begin
        if (en) begin
          wp4_r[j][k] <= PB'(w3_r[j] * cr3_r[j][k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      area4_r <= area3_r;
      side4_r <= side3_r;
    end
  end

  // stage 5: round each term and sum into the field vector
  logic signed [NB-1:0] n5_r [3];
  logic [AREA_BITS-1:0] area5_r;
  side_t                side5_r;

  for (genvar k = 0; k < 3; k++) begin : g_s5
    logic signed [RND_W-1:0] t0, t1, t2;
    assign t0 = rnd_frac(RND_W'(wp4_r[0][k]));
    assign t1 = rnd_frac(RND_W'(wp4_r[1][k]));
    assign t2 = rnd_frac(RND_W'(wp4_r[2][k]));
    always_ff @(posedge clk) begin
      if (en) begin
        n5_r[k] <= NB'($signed(t0[TB-1:0])) + NB'($signed(t1[TB-1:0])) +
                   NB'($signed(t2[TB-1:0]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      area5_r <= area4_r;
      side5_r <= side4_r;
    end
  end

  // stage 6: magnitude, divisor and range check
  logic [NB-1:0] m6_r [3];
  logic [DB-1:0] d6_r;
  dside_t        ds6_r;

  for (genvar k = 0; k < 3; k++) begin : g_s6
    logic [NB-1:0] mag;
    logic [CW-1:0] dsh;
    assign mag = n5_r[k][NB-1] ? NB'(-n5_r[k]) : NB'(n5_r[k]);
    assign dsh = CW'({6'd0, area5_r} * 38'd6) << DIV_SCALE;
    always_ff @(posedge clk) begin
      if (en) begin
        m6_r[k]       <= mag;
        ds6_r.neg[k]  <= n5_r[k][NB-1];
        ds6_r.sat[k]  <= !side5_r.zero && (CW'(mag) >= dsh);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d6_r    <= DB'({3'd0, area5_r} * 35'd6);
      ds6_r.s <= side5_r;
    end
  end

  // stages 7 to 46: divider lanes, side data travels alongside
  logic [DIV_STEPS-1:0] q [3];
  dside_t dsp_r [DIV_STEPS];

  for (genvar k = 0; k < 3; k++) begin : g_div
    logic [CW-1:0] mw;
    assign mw = CW'(m6_r[k]);
    wof_div #(
      .DB    (DB),
      .LOB   (DIV_SCALE),
      .STEPS (DIV_STEPS)
    ) u_div (
      .clk    (clk),
      .en     (en),
      .rem_in (mw[DIV_SCALE +: DB+1]),
      .lo_in  (mw[DIV_SCALE-1:0]),
      .d_in   (d6_r),
      .q_out  (q[k])
    );
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        dsp_r[i] <= (i == 0) ? ds6_r : dsp_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  // stage 47: signed, clamped scaled field
  logic signed [RB-1:0] r47_r [3];
  dside_t               ds47_r;

  for (genvar k = 0; k < 3; k++) begin : g_s47
    logic [RB-1:0] res;
    assign res = RB'(dsp_r[DIV_STEPS-1].sat[k] ? R_MAX : q[k]);
    always_ff @(posedge clk) begin
      if (en) begin
        r47_r[k] <= dsp_r[DIV_STEPS-1].neg[k] ? -$signed(res) : $signed(res);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds47_r <= dsp_r[DIV_STEPS-1];
    end
  end

  // stage 48: projection products
  logic signed [PJ-1:0] pu48_r [3];
  logic signed [PJ-1:0] pv48_r [3];
  dside_t               ds48_r;

  for (genvar k = 0; k < 3; k++) begin : g_s48
    logic signed [CB-1:0] tu, tv;
    assign tu = $signed(ds47_r.s.tx[k*CB +: CB]);
    assign tv = $signed(ds47_r.s.ty[k*CB +: CB]);
    always_ff @(posedge clk) begin
      if (en) begin
        pu48_r[k] <= PJ'(r47_r[k] * tu);
        pv48_r[k] <= PJ'(r47_r[k] * tv);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds48_r <= ds47_r;
    end
  end

  // stage 49: dot products rounded with 12 fraction bits dropped
  logic signed [SB-1:0] su49_r, sv49_r;
  dside_t               ds49_r;
  logic signed [SB-1:0] su_sum, sv_sum;
  logic signed [RND_W-1:0] su_rnd, sv_rnd;

  assign su_sum = SB'(pu48_r[0]) + SB'(pu48_r[1]) + SB'(pu48_r[2]);
  assign sv_sum = SB'(pv48_r[0]) + SB'(pv48_r[1]) + SB'(pv48_r[2]);
  assign su_rnd = rnd_frac(RND_W'(su_sum));
  assign sv_rnd = rnd_frac(RND_W'(sv_sum));

  always_ff @(posedge clk) begin
    if (en) begin
      su49_r <= su_rnd[SB-1:0];
      sv49_r <= sv_rnd[SB-1:0];
      ds49_r <= ds48_r;
    end
  end

  // stage 50: output clamp and status
  localparam logic signed [SB-1:0] O_MAX = SB'(64'sh7fffffff);
  localparam logic signed [SB-1:0] O_MIN = -SB'(64'sh80000000);

  out_t out_r;
  logic hi_u, lo_u, hi_v, lo_v;

  assign hi_u = su49_r > O_MAX;
  assign lo_u = su49_r < O_MIN;
  assign hi_v = sv49_r > O_MAX;
  assign lo_v = sv49_r < O_MIN;

  always_ff @(posedge clk) begin
    if (en) begin
      if (ds49_r.s.zero) begin
        out_r.vec_u  <= '0;
        out_r.vec_v  <= '0;
        out_r.status <= ST_ZERO;
      end else begin
        out_r.vec_u  <= hi_u ? 32'sh7fffffff : lo_u ? 32'sh80000000 : su49_r[31:0];
        out_r.vec_v  <= hi_v ? 32'sh7fffffff : lo_v ? 32'sh80000000 : sv49_r[31:0];
        out_r.status <= ((|ds49_r.sat) || hi_u || lo_u || hi_v || lo_v) ? ST_SAT : ST_OK;
      end
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_data  = out_r;

  `WOF_ASSERT_NOW(a_zero_out, out_valid && out_data.status == ST_ZERO,
    out_data.vec_u == 32'sd0 && out_data.vec_v == 32'sd0)
  `WOF_ASSERT_NOW(a_status_code, out_valid, out_data.status == ST_OK ||
    out_data.status == ST_SAT || out_data.status == ST_ZERO)
  `WOF_ASSERT_NEXT(a_zero_enter, in_valid && in_ready && in_data.face_area == '0,
    vld_r[0] && side1_r.zero)
  `WOF_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(vld_r))

endmodule

[verif/face_vector_checker.sv]
// checker for the whitney face vector block: predicts each result and compares it
`timescale 1ns / 1ps
module face_vector_checker import wof_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_t        out_data,
  output int          fail_count,
  output int          pending_count,
  output int          result_count,
  output int          sat_count,
  output int          zero_count
);

  out_t expected_results[$];

  function automatic longint sext_field(logic [59:0] w, int k);
    logic [19:0] v;
    v = w[k*20 +: 20];
    return longint'(signed'(v));
  endfunction

  // nearest, ties away from zero, drop 12 fraction bits
  function automatic longint round12(longint x);
    longint m;
    m = (x < 0) ? -x : x;
    m = (m + 2048) >>> 12;
    return (x < 0) ? -m : m;
  endfunction

  function automatic out_t predict_face_vector(in_t t);
    out_t res;
    longint p[3][3], nrm[3], tx[3], ty[3], f[3], cr[3][3], acc[3], r[3], e[3];
    longint w, v, s, o, m, q, rm, d;
    logic [59:0] pk[3];
    bit sat;
    pk[0] = t.corner_a;
    pk[1] = t.corner_b;
    pk[2] = t.corner_c;
    sat = 0;
    res = '0;
    if (t.face_area == 0) begin
      res.status = ST_ZERO;
      return res;
    end
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) p[j][k] = sext_field(pk[j], k);
      nrm[k] = sext_field(t.face_normal, k);
      tx[k] = sext_field(t.tangent_x, k);
      ty[k] = sext_field(t.tangent_y, k);
    end
    for (int j = 0; j < 3; j++) begin
      v = (j == 0) ? longint'(t.form_edge0) :
          (j == 1) ? longint'(t.form_edge1) : longint'(t.form_edge2);
      f[j] = (t.edge_flags[j] != t.edge_flags[3+j]) ? v : -v;
      for (int k = 0; k < 3; k++) e[k] = p[(j+1)%3][k] - p[j][k];
      cr[j][0] = round12(e[1]*nrm[2] - e[2]*nrm[1]);
      cr[j][1] = round12(e[2]*nrm[0] - e[0]*nrm[2]);
      cr[j][2] = round12(e[0]*nrm[1] - e[1]*nrm[0]);
    end
    for (int k = 0; k < 3; k++) acc[k] = 0;
    for (int j = 0; j < 3; j++) begin
      w = f[(j+1)%3] - f[(j+2)%3];
      for (int k = 0; k < 3; k++) acc[k] += round12(w * cr[j][k]);
    end
    d = 6 * longint'(t.face_area);
    for (int k = 0; k < 3; k++) begin
      m = (acc[k] < 0) ? -acc[k] : acc[k];
      q = m / d;
      rm = m % d;
      if (q >= (64'sd1 << 20)) begin
        sat = 1;
        r[k] = 64'sd1099511627775;
      end else begin
        r[k] = (q << 20) + ((rm << 20) / d);
      end
      if (acc[k] < 0) r[k] = -r[k];
    end
    for (int b = 0; b < 2; b++) begin
      s = 0;
      for (int k = 0; k < 3; k++) s += r[k] * ((b == 0) ? tx[k] : ty[k]);
      o = round12(s);
      if (o > 64'sd2147483647) begin sat = 1; o = 64'sd2147483647; end
      if (o < -64'sd2147483648) begin sat = 1; o = -64'sd2147483648; end
      if (b == 0) res.vec_u = o[31:0]; else res.vec_v = o[31:0];
    end
    res.status = sat ? ST_SAT : ST_OK;
    return res;
  endfunction

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      fail_count <= 0;
      result_count <= 0;
      sat_count <= 0;
      zero_count <= 0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(predict_face_vector(in_data));
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (out_data.status == ST_SAT) sat_count <= sat_count + 1;
        if (out_data.status == ST_ZERO) zero_count <= zero_count + 1;
        if (expected_results.size() == 0) begin
          $error("result with no item waiting: u=%0d v=%0d", out_data.vec_u, out_data.vec_v);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want != out_data) begin
            if (want.vec_u != out_data.vec_u)
              $error("vec_u expected %0d actual %0d", want.vec_u, out_data.vec_u);
            if (want.vec_v != out_data.vec_v)
              $error("vec_v expected %0d actual %0d", want.vec_v, out_data.vec_v);
            if (want.status != out_data.status)
              $error("status expected %0d actual %0d", want.status, out_data.status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

[verif/whitney_one_form_to_face_vector_top_tb.sv]
// testbench top for the whitney face vector block: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module whitney_one_form_to_face_vector_top_tb;
  import wof_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  in_t  in_data;
  out_t out_data;
  int   fail_count, pending_count, result_count, sat_count, zero_count;
  int   stall_cycles;
  bit   calm_phase;
  bit   stim_done;

  whitney_one_form_to_face_vector_top uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  face_vector_checker chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count), .sat_count(sat_count), .zero_count(zero_count)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic logic [59:0] rand60();
    return 60'({$urandom(), $urandom()});
  endfunction

  function automatic logic [19:0] small_coord(int span);
    return 20'(signed'($urandom_range(0, 2*span)) - span);
  endfunction

  function automatic logic [59:0] small_vec(int span);
    return {small_coord(span), small_coord(span), small_coord(span)};
  endfunction

  // mostly realistic triangles, some raw bit noise
  function automatic in_t random_triangle();
    in_t t;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      t = {rand60(), rand60(), rand60(), rand60(), rand60(), rand60(),
           $urandom(), 24'($urandom()), 24'($urandom()), 24'($urandom()), 6'($urandom())};
    end else begin
      t.corner_a = small_vec(40000);
      t.corner_b = small_vec(40000);
      t.corner_c = small_vec(40000);
      t.face_normal = small_vec(4096);
      t.tangent_x = small_vec(4096);
      t.tangent_y = small_vec(4096);
      t.face_area = (pick == 2) ? $urandom_range(0, 3) : $urandom_range(1, 32'h0400_0000);
      t.form_edge0 = 24'($urandom());
      t.form_edge1 = 24'($urandom_range(0, 8192) - 4096);
      t.form_edge2 = 24'($urandom());
      t.edge_flags = 6'($urandom());
    end
    return t;
  endfunction

  task automatic send_item(in_t t);
    if (!calm_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // output side backpressure
  initial begin
    out_ready = 0;
    @(negedge clk);
    forever begin
      if (!calm_phase && $urandom_range(0, 4) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      out_ready <= 1;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  end

  // watchdog on cycles with no accepted item
  initial begin
    stall_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n ||
          (stim_done && pending_count == 0))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", pending_count);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    in_t t;
    int waited;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    calm_phase = 0;
    stim_done = 0;
    repeat (12) @(negedge clk);
    rst_n = 1;

    // directed: extremes, zero area, sign flag combinations, overflow
    t = '0;
    send_item(t);
    t = '1;
    send_item(t);
    t.face_area = 0;
    send_item(t);
    for (int fl = 0; fl < 8; fl++) begin
      t.corner_a = {20'sd0, 20'sd0, 20'sd0};
      t.corner_b = {20'sd0, 20'sd0, 20'sd4096};
      t.corner_c = {20'sd0, 20'sd4096, 20'sd0};
      t.face_normal = {20'sd4096, 20'sd0, 20'sd0};
      t.tangent_x = {20'sd0, 20'sd0, 20'sd4096};
      t.tangent_y = {20'sd0, 20'sd4096, 20'sd0};
      t.face_area = 32'h0000_8000;
      t.form_edge0 = 24'sd4096;
      t.form_edge1 = -24'sd2048;
      t.form_edge2 = 24'sd1000;
      t.edge_flags = {3'(fl), 3'(fl * 5)};
      send_item(t);
    end
    t.form_edge0 = 24'h7FFFFF;
    t.form_edge1 = 24'h800000;
    t.form_edge2 = 24'h7FFFFF;
    t.face_area = 1;
    send_item(t);
    t.corner_b = {20'h7FFFF, 20'h80000, 20'h7FFFF};
    t.face_normal = {20'h7FFFF, 20'h7FFFF, 20'h80000};
    t.tangent_x = {20'h80000, 20'h80000, 20'h80000};
    t.face_area = 32'hFFFF_FFFF;
    send_item(t);
    t.face_area = 32'd200;
    send_item(t);

    for (int n = 0; n < 1350; n++) begin
      if (n == 1150) calm_phase = 1;
      send_item(random_triangle());
    end
    in_valid <= 0;
    stim_done = 1;

    waited = 0;
    while (pending_count != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    $display("%0d results checked: %0d saturated, %0d zero area", result_count,
             sat_count, zero_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
